FILE: rtl/tbsc_pkg.sv
package tbsc_pkg;

    // Number of dimension fields carried by one descriptor.
    localparam int DIM_FIELDS = 4;

    // Largest rank that the block accepts.
    localparam int MAX_RANK = 4;

    // Width of the log2 of the block element count, and of the bytes per block.
    localparam int BLK_LOG2_W  = 4;
    localparam int BLK_BYTES_W = 9;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TYPE  = 2'd1,
        ST_BAD_SHAPE = 2'd2,
        ST_OVERFLOW  = 2'd3
    } tbsc_status_t;

    typedef enum logic [7:0] {
        TYPE_F32     = 8'd0,
        TYPE_F16     = 8'd1,
        TYPE_Q4_0    = 8'd2,
        TYPE_Q4_1    = 8'd3,
        TYPE_Q5_0    = 8'd6,
        TYPE_Q5_1    = 8'd7,
        TYPE_Q8_0    = 8'd8,
        TYPE_Q8_1    = 8'd9,
        TYPE_Q2_K    = 8'd10,
        TYPE_Q3_K    = 8'd11,
        TYPE_Q4_K    = 8'd12,
        TYPE_Q5_K    = 8'd13,
        TYPE_Q6_K    = 8'd14,
        TYPE_Q8_K    = 8'd15,
        TYPE_IQ2_XXS = 8'd16,
        TYPE_IQ2_XS  = 8'd17,
        TYPE_IQ3_XXS = 8'd18,
        TYPE_IQ1_S   = 8'd19,
        TYPE_IQ4_NL  = 8'd20,
        TYPE_IQ3_S   = 8'd21,
        TYPE_IQ2_S   = 8'd22,
        TYPE_IQ4_XS  = 8'd23,
        TYPE_I8      = 8'd24,
        TYPE_I16     = 8'd25,
        TYPE_I32     = 8'd26,
        TYPE_I64     = 8'd27,
        TYPE_F64     = 8'd28,
        TYPE_IQ1_M   = 8'd29,
        TYPE_BF16    = 8'd30,
        TYPE_TQ1_0   = 8'd34,
        TYPE_TQ2_0   = 8'd35,
        TYPE_MXFP4   = 8'd39,
        TYPE_NVFP4   = 8'd40,
        TYPE_Q1_0    = 8'd41,
        TYPE_Q2_0    = 8'd42
    } tbsc_type_t;

    typedef struct packed {
        logic                   supported;
        logic [BLK_LOG2_W-1:0]  blk_log2;
        logic [BLK_BYTES_W-1:0] blk_bytes;
        logic                   quant;
    } tbsc_type_info_t;

    // Control that travels alongside each descriptor through the multiply chain.
    typedef struct packed {
        logic         valid;
        tbsc_status_t status;
        logic         quant;
        logic         ovf;
    } tbsc_ctl_t;

    function automatic tbsc_type_info_t tbsc_entry(
        input logic [BLK_LOG2_W-1:0]  blk_log2,
        input logic [BLK_BYTES_W-1:0] blk_bytes,
        input logic                   quant
    );
        tbsc_type_info_t e;
        e.supported = 1'b1;
        e.blk_log2  = blk_log2;
        e.blk_bytes = blk_bytes;
        e.quant     = quant;
        return e;
    endfunction

    // Every block element count in the table is a power of two, so it is kept as its log2.
    function automatic tbsc_type_info_t tbsc_type_lookup(input logic [7:0] code);
        tbsc_type_info_t info;
        unique case (tbsc_type_t'(code))
            TYPE_F32:     info = tbsc_entry(4'd0, 9'd4,   1'b0);
            TYPE_F16:     info = tbsc_entry(4'd0, 9'd2,   1'b0);
            TYPE_Q4_0:    info = tbsc_entry(4'd5, 9'd18,  1'b1);
            TYPE_Q4_1:    info = tbsc_entry(4'd5, 9'd20,  1'b1);
            TYPE_Q5_0:    info = tbsc_entry(4'd5, 9'd22,  1'b1);
            TYPE_Q5_1:    info = tbsc_entry(4'd5, 9'd24,  1'b1);
            TYPE_Q8_0:    info = tbsc_entry(4'd5, 9'd34,  1'b1);
            TYPE_Q8_1:    info = tbsc_entry(4'd5, 9'd36,  1'b1);
            TYPE_Q2_K:    info = tbsc_entry(4'd8, 9'd84,  1'b1);
            TYPE_Q3_K:    info = tbsc_entry(4'd8, 9'd110, 1'b1);
            TYPE_Q4_K:    info = tbsc_entry(4'd8, 9'd144, 1'b1);
            TYPE_Q5_K:    info = tbsc_entry(4'd8, 9'd176, 1'b1);
            TYPE_Q6_K:    info = tbsc_entry(4'd8, 9'd210, 1'b1);
            TYPE_Q8_K:    info = tbsc_entry(4'd8, 9'd292, 1'b1);
            TYPE_IQ2_XXS: info = tbsc_entry(4'd8, 9'd66,  1'b1);
            TYPE_IQ2_XS:  info = tbsc_entry(4'd8, 9'd74,  1'b1);
            TYPE_IQ3_XXS: info = tbsc_entry(4'd8, 9'd98,  1'b1);
            TYPE_IQ1_S:   info = tbsc_entry(4'd8, 9'd50,  1'b1);
            TYPE_IQ4_NL:  info = tbsc_entry(4'd5, 9'd18,  1'b1);
            TYPE_IQ3_S:   info = tbsc_entry(4'd8, 9'd110, 1'b1);
            TYPE_IQ2_S:   info = tbsc_entry(4'd8, 9'd82,  1'b1);
            TYPE_IQ4_XS:  info = tbsc_entry(4'd8, 9'd136, 1'b1);
            TYPE_I8:      info = tbsc_entry(4'd0, 9'd1,   1'b0);
            TYPE_I16:     info = tbsc_entry(4'd0, 9'd2,   1'b0);
            TYPE_I32:     info = tbsc_entry(4'd0, 9'd4,   1'b0);
            TYPE_I64:     info = tbsc_entry(4'd0, 9'd8,   1'b0);
            TYPE_F64:     info = tbsc_entry(4'd0, 9'd8,   1'b0);
            TYPE_IQ1_M:   info = tbsc_entry(4'd8, 9'd56,  1'b1);
            TYPE_BF16:    info = tbsc_entry(4'd0, 9'd2,   1'b0);
            TYPE_TQ1_0:   info = tbsc_entry(4'd8, 9'd54,  1'b1);
            TYPE_TQ2_0:   info = tbsc_entry(4'd8, 9'd66,  1'b1);
            TYPE_MXFP4:   info = tbsc_entry(4'd5, 9'd17,  1'b1);
            TYPE_NVFP4:   info = tbsc_entry(4'd6, 9'd36,  1'b1);
            TYPE_Q1_0:    info = tbsc_entry(4'd7, 9'd18,  1'b1);
            TYPE_Q2_0:    info = tbsc_entry(4'd6, 9'd18,  1'b1);
            default:      info = '{supported: 1'b0, blk_log2: '0, blk_bytes: '0, quant: 1'b0};
        endcase
        return info;
    endfunction

endpackage

FILE: rtl/tbsc_mul64.sv
// Two-stage 64 x 64 multiply with wrap detection. The product is built from
// three 32 x 32 partial products; the high-by-high term is never needed because
// both high halves being nonzero already means the product exceeds 64 bits.
module tbsc_mul64
    import tbsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tbsc_ctl_t   ctl_in,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output tbsc_ctl_t   ctl_out,
    output logic [63:0] p
);

    tbsc_ctl_t   ctl_a_reg;
    tbsc_ctl_t   ctl_b_reg;
    tbsc_ctl_t   ctl_b_next;
    logic [63:0] pll_reg;
    logic [63:0] phl_reg;
    logic [63:0] plh_reg;
    logic        both_hi_reg;
    logic [63:0] p_reg;
    logic [63:0] p_next;
    logic [65:0] mid;

    always_comb
    begin
        mid = {2'b00, phl_reg} + {2'b00, plh_reg} + {34'd0, pll_reg[63:32]};
        p_next = {mid[31:0], pll_reg[31:0]};
        ctl_b_next = ctl_a_reg;
        ctl_b_next.ovf = ctl_a_reg.ovf | both_hi_reg | (mid[65:32] != 34'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pll_reg     <= a[31:0]  * b[31:0];
        phl_reg     <= a[63:32] * b[31:0];
        plh_reg     <= a[31:0]  * b[63:32];
        both_hi_reg <= (a[63:32] != 32'd0) && (b[63:32] != 32'd0);
        p_reg       <= p_next;
    end

    assign ctl_out = ctl_b_reg;
    assign p       = p_reg;

endmodule

FILE: rtl/tensor_byte_size_calc.sv
// Tensor byte-size calculator. A descriptor is taken at every clock edge where
// start is high; busy is always low because the pipeline never stalls. Each
// descriptor yields one result on status, payload_bytes and is_quantized, marked by
// done for a single cycle, in the order the descriptors arrived. One descriptor
// per cycle is sustained: the first stage decodes the type and checks the shape,
// the second scales the block count by the bytes per block, and each further
// dimension passes through its own two-stage 64-bit multiplier built from 32-bit
// partial products. The receiver must take every result in the cycle it appears.
module tensor_byte_size_calc
    import tbsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  elem_type,
    input  logic [2:0]  rank,
    input  logic [63:0] dim0,
    input  logic [63:0] dim1,
    input  logic [63:0] dim2,
    input  logic [63:0] dim3,
    output logic        done,
    output logic [1:0]  status,
    output logic [63:0] payload_bytes,
    output logic        is_quantized
);

    localparam int PIPE_LATENCY = 3 + 2 * (DIM_FIELDS - 1);

    tbsc_type_info_t        info;
    logic [63:0]            dims_in [0:DIM_FIELDS-1];
    logic                   rank_bad;
    logic                   zero_dim;
    logic                   partial;
    logic [63:0]            blk_mask;

    tbsc_ctl_t              ctl_s1_reg;
    tbsc_ctl_t              ctl_s1_next;
    logic [63:0]            blocks_s1_reg;
    logic [BLK_BYTES_W-1:0] bb_s1_reg;
    logic [63:0]            dims_s1_reg [1:DIM_FIELDS-1];
    logic [63:0]            dims_s1_next [1:DIM_FIELDS-1];

    tbsc_ctl_t              ctl_s2_reg;
    tbsc_ctl_t              ctl_s2_next;
    logic [63:0]            prod_s2_reg;
    logic [72:0]            prod_wide;

    tbsc_ctl_t              ctl_chain [0:DIM_FIELDS-1];
    logic [63:0]            prod_chain [0:DIM_FIELDS-1];

    logic                   done_reg;
    tbsc_status_t           status_reg;
    tbsc_status_t           status_next;
    logic [63:0]            payload_bytes_reg;
    logic [63:0]            payload_bytes_next;
    logic                   quant_reg;

    assign busy = 1'b0;

    assign dims_in[0] = dim0;
    assign dims_in[1] = dim1;
    assign dims_in[2] = dim2;
    assign dims_in[3] = dim3;

    // Stage 1: type decode, shape checks and the block count.
    always_comb
    begin
        info     = tbsc_type_lookup(elem_type);
        rank_bad = (rank == 3'd0) || (int'(rank) > MAX_RANK) || (int'(rank) > DIM_FIELDS);
        zero_dim = 1'b0;
        for (int i = 0; i < DIM_FIELDS; i++)
        begin
            if ((i < int'(rank)) && (dims_in[i] == 64'd0))
            begin
                zero_dim = 1'b1;
            end
        end
        blk_mask = (64'd1 << info.blk_log2) - 64'd1;
        partial  = (dim0 & blk_mask) != 64'd0;

        ctl_s1_next.valid = start;
        ctl_s1_next.quant = info.quant;
        ctl_s1_next.ovf   = 1'b0;
        if (!info.supported)
        begin
            ctl_s1_next.status = ST_BAD_TYPE;
        end
        else if (rank_bad || zero_dim || partial)
        begin
            ctl_s1_next.status = ST_BAD_SHAPE;
        end
        else
        begin
            ctl_s1_next.status = ST_OK;
        end

        // Dimensions beyond the rank multiply in as one.
        for (int k = 1; k < DIM_FIELDS; k++)
        begin
            dims_s1_next[k] = (k < int'(rank)) ? dims_in[k] : 64'd1;
        end
    end

    // Stage 2: blocks times bytes per block.
    always_comb
    begin
        prod_wide       = blocks_s1_reg * bb_s1_reg;
        ctl_s2_next     = ctl_s1_reg;
        ctl_s2_next.ovf = prod_wide[72:64] != 9'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_s1_reg <= '0;
            ctl_s2_reg <= '0;
        end
        else
        begin
            ctl_s1_reg <= ctl_s1_next;
            ctl_s2_reg <= ctl_s2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blocks_s1_reg <= dim0 >> info.blk_log2;
        bb_s1_reg     <= info.blk_bytes;
        dims_s1_reg   <= dims_s1_next;
        prod_s2_reg   <= prod_wide[63:0];
    end

    assign ctl_chain[0]  = ctl_s2_reg;
    assign prod_chain[0] = prod_s2_reg;

    // Dimension k passes through its delay line dly_reg so that it meets its multiplier together
    // with the running product.
    for (genvar k = 1; k < DIM_FIELDS; k++)
    begin : g_dim
        logic [63:0] dly_reg [0:2*k-2];

        always_ff @(posedge clk)
        begin
            dly_reg[0] <= dims_s1_reg[k];
            for (int j = 1; j <= 2 * k - 2; j++)
            begin
                dly_reg[j] <= dly_reg[j-1];
            end
        end

        tbsc_mul64 u_mul
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_chain[k-1]),
            .a       (prod_chain[k-1]),
            .b       (dly_reg[2*k-2]),
            .ctl_out (ctl_chain[k]),
            .p       (prod_chain[k])
        );
    end

    // Output stage: an earlier error wins over overflow.
    always_comb
    begin
        if (ctl_chain[DIM_FIELDS-1].status != ST_OK)
        begin
            status_next        = ctl_chain[DIM_FIELDS-1].status;
            payload_bytes_next = 64'd0;
        end
        else if (ctl_chain[DIM_FIELDS-1].ovf)
        begin
            status_next        = ST_OVERFLOW;
            payload_bytes_next = 64'd0;
        end
        else
        begin
            status_next        = ST_OK;
            payload_bytes_next = prod_chain[DIM_FIELDS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_chain[DIM_FIELDS-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg        <= status_next;
        payload_bytes_reg <= payload_bytes_next;
        quant_reg         <= ctl_chain[DIM_FIELDS-1].quant;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign payload_bytes = payload_bytes_reg;
    assign is_quantized  = quant_reg;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("accepted descriptor did not complete after the pipeline latency");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result strobe without a matching accepted descriptor");

    a_error_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (payload_bytes == 64'd0))
        else $error("nonzero byte size reported with an error status");

    a_bad_type_unquantized: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_BAD_TYPE) |-> !is_quantized)
        else $error("unsupported type reported as quantized");

endmodule
